/* rtl/bsmh_pkg.sv */
// Shared types and constants for the box stacking height unit.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package bsmh_pkg;

  localparam int MaxBoxes  = 32;
  localparam int DimBits   = 16;
  localparam int Orients   = 6;
  localparam int NumOr     = Orients * MaxBoxes;
  localparam int IdxW      = $clog2(NumOr + 1);
  localparam int HeightW   = 24;
  localparam int KW        = 3;

  localparam logic [HeightW-1:0] HeightMax = {HeightW{1'b1}};
  localparam logic [IdxW-1:0]    NumOrIdx  = IdxW'(NumOr);
  localparam logic [KW-1:0]      KLast     = KW'(Orients - 1);

  typedef logic [DimBits-1:0] dim_t;

  // One orientation: base x, base y, height z.
  typedef struct packed {
    dim_t x;
    dim_t y;
    dim_t z;
  } orient_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the input box
    logic expand;   // write one orientation of the latched box
    logic rd_key;   // read the entry at the outer index
    logic ld_key;   // latch the key and clear the scan state
    logic scan;     // read the next inner entry
    logic wr_rank;  // write the key to its sorted position
    logic wr_best;  // write the best height of the outer entry
    logic next_i;   // advance the outer index
    logic clr_i;    // restart the outer index
    logic clr_all;  // restart the outer index and the result
    logic fin;      // empty the box set
    logic dp;       // 0: ranking phase, 1: chain phase
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic k_last;
    logic last;
    logic scan_last;
    logic i_last;
    logic i_zero;
  } stat_t;

endpackage

/* rtl/bsmh_ctrl.sv */
// Controller state machine of the box stacking height unit.
// Depends on bsmh_pkg for the command and status types.
`timescale 1ns / 1ps

module bsmh_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           last_box_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  bsmh_pkg::stat_t stat_i,
  output bsmh_pkg::cmd_t  cmd_o
);
  import bsmh_pkg::*;

  typedef enum logic [7:0] {
    StIdle   = 8'b0000_0001,
    StExpand = 8'b0000_0010,
    StKeyRd  = 8'b0000_0100,
    StKeyLd  = 8'b0000_1000,
    StScan   = 8'b0001_0000,
    StDrain  = 8'b0010_0000,
    StWrite  = 8'b0100_0000,
    StOut    = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   dp_q, dp_d;

  // State register and phase flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      dp_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      dp_q    <= dp_d;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_d     = state_q;
    dp_d        = dp_q;
    cmd_o       = '0;
    cmd_o.dp    = dp_q;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          if (!stat_i.full) begin
            state_d = StExpand;
          end else if (last_box_i) begin
            cmd_o.clr_all = 1'b1;
            dp_d          = 1'b0;
            state_d       = StKeyRd;
          end
        end
      end
      StExpand: begin
        cmd_o.expand = 1'b1;
        if (stat_i.k_last) begin
          if (stat_i.last) begin
            cmd_o.clr_all = 1'b1;
            dp_d          = 1'b0;
            state_d       = StKeyRd;
          end else begin
            state_d = StIdle;
          end
        end
      end
      StKeyRd: begin
        cmd_o.rd_key = 1'b1;
        state_d      = StKeyLd;
      end
      StKeyLd: begin
        cmd_o.ld_key = 1'b1;
        state_d      = (dp_q && stat_i.i_zero) ? StWrite : StScan;
      end
      StScan: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_last) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        state_d = StWrite;
      end
      StWrite: begin
        cmd_o.wr_rank = !dp_q;
        cmd_o.wr_best = dp_q;
        cmd_o.next_i  = 1'b1;
        if (stat_i.i_last) begin
          if (!dp_q) begin
            cmd_o.clr_i = 1'b1;
            dp_d        = 1'b1;
            state_d     = StKeyRd;
          end else begin
            state_d = StOut;
          end
        end else begin
          state_d = StKeyRd;
        end
      end
      StOut: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          cmd_o.fin = 1'b1;
          state_d   = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

/* rtl/bsmh_datapath.sv */
// Datapath of the box stacking height unit: orientation memories, sort ranking,
// chain height scan and the result register. Depends on bsmh_pkg.
`timescale 1ns / 1ps

module bsmh_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bsmh_pkg::dim_t                dim_a_i,
  input  bsmh_pkg::dim_t                dim_b_i,
  input  bsmh_pkg::dim_t                dim_c_i,
  input  logic                          last_box_i,
  input  bsmh_pkg::cmd_t                cmd_i,
  output bsmh_pkg::stat_t               stat_o,
  output logic [bsmh_pkg::HeightW-1:0]  max_height_o
);
  import bsmh_pkg::*;

  localparam int AW = $clog2(NumOr);

  // Unsorted orientations, sorted orientations and best heights.
  orient_t              u_mem [NumOr];
  orient_t              s_mem [NumOr];
  logic [HeightW-1:0]   b_mem [NumOr];
  orient_t              u_rd_q, s_rd_q;
  logic [HeightW-1:0]   b_rd_q;

  dim_t               a_q, b_q, c_q;
  logic               last_q;
  logic [KW-1:0]      k_q;
  logic [IdxW-1:0]    n_q, i_q, j_q, jd_q, rank_q;
  logic               vld_q;
  orient_t            key_q;
  logic [HeightW:0]   cur_q, cand;
  logic [HeightW-1:0] best_q, sat;
  orient_t            orient_new;
  logic [IdxW-1:0]    rd_idx, scan_lim;
  logic               sorts_ahead, carry;

  // Orientation of the latched box selected by the expansion counter.
  always_comb begin
    case (k_q)
      3'd0:    orient_new = '{x: a_q, y: b_q, z: c_q};
      3'd1:    orient_new = '{x: a_q, y: c_q, z: b_q};
      3'd2:    orient_new = '{x: b_q, y: a_q, z: c_q};
      3'd3:    orient_new = '{x: b_q, y: c_q, z: a_q};
      3'd4:    orient_new = '{x: c_q, y: a_q, z: b_q};
      default: orient_new = '{x: c_q, y: b_q, z: a_q};
    endcase
  end

  assign rd_idx = cmd_i.rd_key ? i_q : j_q;

  // Memory writes and registered reads.
  always_ff @(posedge clk_i) begin
    if (cmd_i.expand) begin
      u_mem[n_q[AW-1:0]] <= orient_new;
    end
    if (cmd_i.wr_rank) begin
      s_mem[rank_q[AW-1:0]] <= key_q;
    end
    if (cmd_i.wr_best) begin
      b_mem[i_q[AW-1:0]] <= sat;
    end
    u_rd_q <= u_mem[rd_idx[AW-1:0]];
    s_rd_q <= s_mem[rd_idx[AW-1:0]];
    b_rd_q <= b_mem[rd_idx[AW-1:0]];
  end

  // Comparisons against the key for the two phases.
  assign sorts_ahead = (u_rd_q > key_q) || ((u_rd_q == key_q) && (jd_q < i_q));
  assign carry  = ((s_rd_q.x > key_q.x) && (s_rd_q.y > key_q.y)) ||
                  ((s_rd_q.y > key_q.x) && (s_rd_q.x > key_q.y));
  assign cand   = {1'b0, b_rd_q} + (HeightW + 1)'(key_q.z);
  assign sat    = (cur_q > (HeightW + 1)'(HeightMax)) ? HeightMax : cur_q[HeightW-1:0];

  // Input box, key and delayed scan index latches; they need no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      a_q <= dim_a_i;
      b_q <= dim_b_i;
      c_q <= dim_c_i;
    end
    if (cmd_i.ld_key) begin
      key_q <= cmd_i.dp ? s_rd_q : u_rd_q;
    end
    if (cmd_i.scan) begin
      jd_q <= j_q;
    end
  end

  // Counters, scan accumulators and the result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= 1'b0;
      k_q    <= '0;
      n_q    <= '0;
      i_q    <= '0;
      j_q    <= '0;
      vld_q  <= 1'b0;
      rank_q <= '0;
      cur_q  <= '0;
      best_q <= '0;
    end else begin
      vld_q <= cmd_i.scan;
      if (cmd_i.capture) begin
        last_q <= last_box_i;
        k_q    <= '0;
      end
      if (cmd_i.expand) begin
        n_q <= n_q + 1'b1;
        k_q <= k_q + 1'b1;
      end
      if (cmd_i.fin) begin
        n_q <= '0;
      end
      if (cmd_i.clr_all || cmd_i.clr_i) begin
        i_q <= '0;
      end else if (cmd_i.next_i) begin
        i_q <= i_q + 1'b1;
      end
      if (cmd_i.clr_all) begin
        best_q <= '0;
      end else if (cmd_i.wr_best && (sat > best_q)) begin
        best_q <= sat;
      end
      if (cmd_i.ld_key) begin
        j_q    <= '0;
        rank_q <= '0;
        cur_q  <= (HeightW + 1)'(s_rd_q.z);
      end else begin
        if (cmd_i.scan) begin
          j_q <= j_q + 1'b1;
        end
        if (vld_q && !cmd_i.dp && sorts_ahead) begin
          rank_q <= rank_q + 1'b1;
        end
        if (vld_q && cmd_i.dp && carry && (cand > cur_q)) begin
          cur_q <= cand;
        end
      end
    end
  end

  assign scan_lim         = cmd_i.dp ? i_q : n_q;
  assign stat_o.full      = (n_q == NumOrIdx);
  assign stat_o.k_last    = (k_q == KLast);
  assign stat_o.last      = last_q;
  assign stat_o.scan_last = (j_q == scan_lim - 1'b1);
  assign stat_o.i_last    = (i_q == n_q - 1'b1);
  assign stat_o.i_zero    = (i_q == '0);
  assign max_height_o     = best_q;

endmodule

/* rtl/box_stacking_max_height_unit.sv */
// Top level of the box stacking height unit.
// Instantiates bsmh_ctrl and bsmh_datapath; depends on bsmh_pkg.
`timescale 1ns / 1ps

// Boxes arrive one per transaction; each box is accepted and then its six
// orientations are written into the orientation memory. Up to 32 boxes are
// kept; further boxes are dropped until a box marked last_box, which is itself
// stored when there is room, and then starts the computation. With n stored
// orientations (six per box) a rank pass scans all n entries for each
// orientation, counting the entries that sort before it through the one read
// port of the memory, and a chain pass scans the i entries before orientation
// i (none for the first) for its possible carriers. The result is then held
// until it is taken, and the unit stalls its input in every state but idle:
// while it writes the orientations of a box, and from the start of the
// computation to the delivery of the result.
module box_stacking_max_height_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  bsmh_pkg::dim_t                dim_a_i,
  input  bsmh_pkg::dim_t                dim_b_i,
  input  bsmh_pkg::dim_t                dim_c_i,
  input  logic                          last_box_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bsmh_pkg::HeightW-1:0]  max_height_o
);
  import bsmh_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencing of load, rank and chain phases.
  bsmh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_box_i  (last_box_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Memories and arithmetic.
  bsmh_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .dim_a_i      (dim_a_i),
    .dim_b_i      (dim_b_i),
    .dim_c_i      (dim_c_i),
    .last_box_i   (last_box_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .max_height_o (max_height_o)
  );

endmodule

/* test/box_stacking_max_height_unit_tb.sv */
// Testbench for box_stacking_max_height_unit: box sets in, greatest stack height out.
// Depends on bsmh_pkg and the unit; a built-in height predictor checks every result.
`timescale 1ns / 1ps

module box_stacking_max_height_unit_tb;
  import bsmh_pkg::*;

  localparam int CycleLimit = 4000000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  dim_t                 dim_a_i;
  dim_t                 dim_b_i;
  dim_t                 dim_c_i;
  logic                 last_box_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [HeightW-1:0]   max_height_o;

  // Boxes of the set being loaded, as the unit should hold them.
  dim_t                 set_a[$];
  dim_t                 set_b[$];
  dim_t                 set_c[$];
  logic [HeightW-1:0]   height_fifo[$];
  int                   fail_count;
  int                   cycle_count;
  int                   stall_level;

  box_stacking_max_height_unit u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .dim_a_i      (dim_a_i),
    .dim_b_i      (dim_b_i),
    .dim_c_i      (dim_c_i),
    .last_box_i   (last_box_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .max_height_o (max_height_o)
  );

  // Clock generation.
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Greatest stack height of the current set: six orientations per box, a
  // descending sort, then the longest weighted chain with saturation.
  function automatic logic [HeightW-1:0] stack_height();
    int unsigned ox[NumOr];
    int unsigned oy[NumOr];
    int unsigned oz[NumOr];
    longint unsigned best_of[NumOr];
    int unsigned kx, ky, kz;
    longint unsigned cur, best;
    int n, i, j;
    n = 0;
    best = 0;
    for (i = 0; i < set_a.size(); i++) begin
      ox[n] = set_a[i]; oy[n] = set_b[i]; oz[n] = set_c[i]; n++;
      ox[n] = set_a[i]; oy[n] = set_c[i]; oz[n] = set_b[i]; n++;
      ox[n] = set_b[i]; oy[n] = set_a[i]; oz[n] = set_c[i]; n++;
      ox[n] = set_b[i]; oy[n] = set_c[i]; oz[n] = set_a[i]; n++;
      ox[n] = set_c[i]; oy[n] = set_a[i]; oz[n] = set_b[i]; n++;
      ox[n] = set_c[i]; oy[n] = set_b[i]; oz[n] = set_a[i]; n++;
    end
    for (i = 1; i < n; i++) begin
      kx = ox[i]; ky = oy[i]; kz = oz[i];
      j = i;
      while (j > 0 && (kx != ox[j-1] ? kx > ox[j-1] :
                       ky != oy[j-1] ? ky > oy[j-1] : kz > oz[j-1])) begin
        ox[j] = ox[j-1]; oy[j] = oy[j-1]; oz[j] = oz[j-1];
        j--;
      end
      ox[j] = kx; oy[j] = ky; oz[j] = kz;
    end
    for (i = 0; i < n; i++) begin
      cur = oz[i];
      for (j = 0; j < i; j++) begin
        if ((ox[j] > ox[i] && oy[j] > oy[i]) || (oy[j] > ox[i] && ox[j] > oy[i])) begin
          if (best_of[j] + oz[i] > cur) cur = best_of[j] + oz[i];
        end
      end
      if (cur > HeightMax) cur = HeightMax;
      best_of[i] = cur;
      if (cur > best) best = cur;
    end
    return best[HeightW-1:0];
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Sends one box and updates the prediction once the transaction is taken.
  task automatic send_box(input dim_t a, input dim_t b, input dim_t c, input logic last);
    int gap;
    in_valid_i <= 1'b1;
    dim_a_i    <= a;
    dim_b_i    <= b;
    dim_c_i    <= c;
    last_box_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (set_a.size() < MaxBoxes) begin
      set_a.push_back(a);
      set_b.push_back(b);
      set_c.push_back(c);
    end
    if (last) begin
      height_fifo.push_back(stack_height());
      set_a.delete();
      set_b.delete();
      set_c.delete();
    end
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Sends a set of random boxes with dimensions up to dim_hi.
  task automatic send_set(input int boxes, input int unsigned dim_hi);
    for (int k = 0; k < boxes; k++) begin
      send_box(dim_t'($urandom_range(0, dim_hi)), dim_t'($urandom_range(0, dim_hi)),
               dim_t'($urandom_range(0, dim_hi)), k == boxes - 1);
    end
  endtask

  // Extremes of the fields, zero sizes, single-box sets and short multi-box sets.
  task automatic test_directed();
    send_box(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    send_box(16'd1, 16'd1, 16'd1, 1'b1);
    send_box(16'd0, 16'd0, 16'd0, 1'b1);
    send_box(16'd0, 16'd5, 16'hFFFF, 1'b1);
    send_box(16'd1, 16'd2, 16'd3, 1'b0);
    send_box(16'd4, 16'd5, 16'd6, 1'b1);
    send_box(16'hFFFF, 16'hFFFE, 16'hFFFD, 1'b0);
    send_box(16'h8000, 16'h7FFF, 16'h5555, 1'b0);
    send_box(16'hAAAA, 16'h0001, 16'hFFFF, 1'b1);
    send_box(16'd10, 16'd20, 16'd30, 1'b0);
    send_box(16'd10, 16'd20, 16'd30, 1'b0);
    send_box(16'd30, 16'd20, 16'd10, 1'b1);
  endtask

  // Two sets past the store size: extra boxes are dropped, the last included.
  task automatic test_store_full();
    send_set(MaxBoxes + 3, 65535);
    for (int k = 0; k < MaxBoxes; k++) begin
      send_box(dim_t'(k + 1), dim_t'(k + 2), dim_t'(16'hFFFF - k), 1'b0);
    end
    send_box(16'd1000, 16'd1000, 16'd1000, 1'b1);
  endtask

  // Random sets, mostly small ones with small sizes so that chains form.
  task automatic test_random();
    int sent;
    int boxes;
    sent = 0;
    while (sent < 1000) begin
      boxes = ($urandom_range(0, 99) < 97) ? $urandom_range(1, 5) : $urandom_range(20, 32);
      if ($urandom_range(0, 3) == 0) send_set(boxes, 65535);
      else send_set(boxes, $urandom_range(1, 40));
      sent += boxes;
    end
  endtask

  // Result side stall, with calm stretches and busy stretches.
  always @(posedge clk_i) begin
    if ($urandom_range(0, 199) == 0) stall_level <= $urandom_range(0, 3) * 25;
    out_stall_i <= ($urandom_range(0, 99) < stall_level) ? 1'b1 : 1'b0;
  end

  // Compares every result transaction with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (height_fifo.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual max_height %0d",
                 $time, max_height_o);
        fail_count++;
      end else begin
        if (max_height_o !== height_fifo[0]) begin
          $display("%0t: max_height mismatch, expected %0d, actual %0d",
                   $time, height_fifo[0], max_height_o);
          fail_count++;
        end
        void'(height_fifo.pop_front());
      end
    end
  end

  // Run time limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    fail_count  = 0;
    cycle_count = 0;
    stall_level = 0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    dim_a_i     = '0;
    dim_b_i     = '0;
    dim_c_i     = '0;
    last_box_i  = 1'b0;
    out_stall_i = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_store_full();
    test_random();
    in_valid_i <= 1'b0;
    while (height_fifo.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
